>>> rtl/core/c8_pkg.sv
package c8_pkg;

    localparam int MemDepthDefault   = 4096;
    localparam int StackDepthDefault = 16;
    localparam logic [11:0] PcResetDefault = 12'h200;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    localparam logic [0:0] REG_PROGRAM_START = 1'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_HI,
        S_FETCH_LO,
        S_DECODE,
        S_CLS,
        S_DRW_RD,
        S_DRW_ROW,
        S_BCD,
        S_STORE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_OUT
    } state_t;

endpackage

>>> rtl/core/c8_ram.sv
module c8_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/chip8_cpu_core.sv
// CHIP-8 interpreter core. Each transaction on the s_ channel writes one memory
// byte, executes one instruction, reads one display row or, for the unused
// opcode, does nothing; exactly one result follows on the m_ channel. A memory
// write or row read presents its result in the cycle after it is accepted; the
// core then returns from S_OUT to S_IDLE before it takes the next one. An
// instruction presents its result after S_FETCH_HI, S_FETCH_LO and S_DECODE
// plus the work of the instruction: CLS walks 32 display rows (one per cycle),
// DRW reads and then writes each sprite row (S_DRW_RD, S_DRW_ROW), BCD writes
// three digits, Fx55 stores and Fx65 reads then loads each register. The byte
// memory with its registered read port and the one-row-per-cycle display access
// set these steps. No item is taken until the previous result has been accepted.
module chip8_cpu_core #(
    parameter int MEM_DEPTH   = c8_pkg::MemDepthDefault,
    parameter int STACK_DEPTH = c8_pkg::StackDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [11:0] s_address,
    input  logic [7:0]  s_data,
    input  logic [4:0]  s_row,
    input  logic [15:0] s_key_mask,
    input  logic [7:0]  s_random_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pc,
    output logic [63:0] m_row_pixels,
    output logic        m_display_changed,
    output logic        m_waiting_key,
    output logic [1:0]  m_status
);
    import c8_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;

    logic [11:0] start_reg;
    logic [11:0] pc_reg, pc_next;
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [15:0] i_reg, i_next;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [11:0] stk_rdata;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [63:0] fb_reg [32];
    logic        fb_we;
    logic [4:0]  fb_idx;
    logic [63:0] fb_wdata;

    logic [15:0] key_reg;
    logic [7:0]  rnd_reg;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] ir_reg, ir_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        hit_reg, hit_next;
    logic        chg_reg, chg_next;
    logic        wait_reg, wait_next;
    logic [1:0]  sts_reg, sts_next;
    logic [63:0] pix_reg, pix_next;
    logic        push;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    c8_ram #(.Width(8), .Depth(MEM_DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // return stack: the read port always points at the top entry
    c8_ram #(.Width(12), .Depth(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (push),
        .waddr (SW'(lvl_reg)),
        .wdata (pc_reg + 12'd2),
        .raddr (SW'(lvl_reg - 1'b1)),
        .rdata (stk_rdata)
    );

    // fold the 12-bit address into the memory depth (at most eight times it)
    function automatic logic [AW-1:0] maddr(input logic [15:0] a);
        logic [14:0] t;
        t = {3'd0, a[11:0]};
        if (t >= 15'(4 * MEM_DEPTH)) t = t - 15'(4 * MEM_DEPTH);
        if (t >= 15'(2 * MEM_DEPTH)) t = t - 15'(2 * MEM_DEPTH);
        if (t >= 15'(MEM_DEPTH)) t = t - 15'(MEM_DEPTH);
        return t[AW-1:0];
    endfunction

    assign pready = 1'b1;
    assign prdata = {20'd0, start_reg};
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite && (paddr == {REG_PROGRAM_START, 1'b0});

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_pc = pc_reg;
    assign m_row_pixels = pix_reg;
    assign m_display_changed = chg_reg;
    assign m_waiting_key = wait_reg;
    assign m_status = sts_reg;

    logic [3:0] fx, fy, fn;
    logic [7:0] vx, vy;
    assign fx = ir_reg[11:8];
    assign fy = ir_reg[7:4];
    assign fn = ir_reg[3:0];
    assign vx = v_reg[fx];
    assign vy = v_reg[fy];

    logic [15:0] i_off;
    assign i_off = i_reg + {11'd0, cnt_reg};

    // sprite row mask, rotated into place
    logic [63:0] spr_mask;
    logic [5:0]  col;
    always_comb begin
        spr_mask = '0;
        for (int c = 0; c < 8; c++) begin
            col = vx[5:0] + 6'(c);
            if (mem_rdata[7 - c]) spr_mask[col] = 1'b1;
        end
    end

    // BCD digits of vx
    logic [7:0] hund, tens, ones, rem1;
    always_comb begin
        hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        rem1 = vx - 8'((hund * 8'd100));
        tens = 8'((16'(rem1) * 16'd205) >> 11);
        ones = rem1 - 8'(tens * 8'd10);
    end

    logic [4:0] key_first;
    always_comb begin
        key_first = 5'd16;
        for (int k = 15; k >= 0; k--) begin
            if (key_reg[k]) key_first = 5'(k);
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        for (int k = 0; k < 16; k++) v_next[k] = v_reg[k];
        i_next = i_reg;
        dt_next = dt_reg;
        st_next = st_reg;
        lvl_next = lvl_reg;
        hi_next = hi_reg;
        ir_next = ir_reg;
        cnt_next = cnt_reg;
        hit_next = hit_reg;
        chg_next = chg_reg;
        wait_next = wait_reg;
        sts_next = sts_reg;
        pix_next = pix_reg;
        push = 1'b0;
        mem_we = 1'b0;
        mem_waddr = maddr(i_off);
        mem_wdata = v_reg[cnt_reg[3:0]];
        mem_raddr = maddr({4'd0, pc_reg});
        fb_we = 1'b0;
        fb_idx = cnt_reg;
        fb_wdata = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    chg_next = 1'b0;
                    wait_next = 1'b0;
                    sts_next = ST_OK;
                    pix_next = '0;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    case (s_opcode)
                        OP_WRITE: begin
                            mem_we = 1'b1;
                            mem_waddr = maddr({4'd0, s_address});
                            mem_wdata = s_data;
                            state_next = S_OUT;
                        end
                        OP_EXEC: state_next = S_FETCH_HI;
                        OP_READ: begin
                            pix_next = fb_reg[s_row];
                            state_next = S_OUT;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_FETCH_HI: begin
                hi_next = mem_rdata;
                mem_raddr = maddr({4'd0, pc_reg + 12'd1});
                state_next = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                mem_raddr = maddr({4'd0, pc_reg + 12'd1});
                state_next = S_DECODE;
            end
            S_DECODE: begin
                ir_next = {hi_reg, mem_rdata};
                state_next = S_OUT;
                // decode the fetched word directly
                begin
                    logic [15:0] op;
                    logic [3:0] x, y, n;
                    logic [7:0] k8, ax, ay;
                    logic [8:0] sum;
                    op = {hi_reg, mem_rdata};
                    x = op[11:8]; y = op[7:4]; n = op[3:0]; k8 = op[7:0];
                    ax = v_reg[x]; ay = v_reg[y];
                    sum = 9'(ax) + 9'(ay);
                    pc_next = pc_reg + 12'd2;
                    case (op[15:12])
                        4'h0: begin
                            if (op == 16'h00E0) begin
                                state_next = S_CLS;
                            end else if (op == 16'h00EE) begin
                                if (lvl_reg == '0) sts_next = ST_UNDERFLOW;
                                else begin
                                    lvl_next = lvl_reg - 1'b1;
                                    pc_next = stk_rdata;
                                end
                            end
                        end
                        4'h1: pc_next = op[11:0];
                        4'h2: begin
                            if (lvl_reg >= LW'(STACK_DEPTH)) sts_next = ST_OVERFLOW;
                            else begin
                                push = 1'b1;
                                lvl_next = lvl_reg + 1'b1;
                                pc_next = op[11:0];
                            end
                        end
                        4'h3: if (ax == k8) pc_next = pc_reg + 12'd4;
                        4'h4: if (ax != k8) pc_next = pc_reg + 12'd4;
                        4'h5: begin
                            if (n != 4'd0) sts_next = ST_UNKNOWN;
                            else if (ax == ay) pc_next = pc_reg + 12'd4;
                        end
                        4'h6: v_next[x] = k8;
                        4'h7: v_next[x] = ax + k8;
                        4'h8: begin
                            case (n)
                                4'h0: v_next[x] = ay;
                                4'h1: v_next[x] = ax | ay;
                                4'h2: v_next[x] = ax & ay;
                                4'h3: v_next[x] = ax ^ ay;
                                4'h4: begin
                                    v_next[x] = sum[7:0];
                                    v_next[15] = {7'd0, sum[8]};
                                end
                                4'h5: begin
                                    v_next[x] = ax - ay;
                                    v_next[15] = {7'd0, ax >= ay};
                                end
                                4'h6: begin
                                    v_next[x] = {1'b0, ax[7:1]};
                                    v_next[15] = {7'd0, ax[0]};
                                end
                                4'h7: begin
                                    v_next[x] = ay - ax;
                                    v_next[15] = {7'd0, ay >= ax};
                                end
                                4'hE: begin
                                    v_next[x] = {ax[6:0], 1'b0};
                                    v_next[15] = {7'd0, ax[7]};
                                end
                                default: sts_next = ST_UNKNOWN;
                            endcase
                        end
                        4'h9: begin
                            if (n != 4'd0) sts_next = ST_UNKNOWN;
                            else if (ax != ay) pc_next = pc_reg + 12'd4;
                        end
                        4'hA: i_next = {4'd0, op[11:0]};
                        4'hB: pc_next = op[11:0] + {4'd0, v_reg[0]};
                        4'hC: v_next[x] = rnd_reg & k8;
                        4'hD: begin
                            pc_next = pc_reg;
                            state_next = (n == 4'd0) ? S_OUT : S_DRW_RD;
                            if (n == 4'd0) begin
                                v_next[15] = 8'd0;
                                pc_next = pc_reg + 12'd2;
                            end
                        end
                        4'hE: begin
                            if (k8 == 8'h9E) begin
                                if (key_reg[ax[3:0]]) pc_next = pc_reg + 12'd4;
                            end else if (k8 == 8'hA1) begin
                                if (!key_reg[ax[3:0]]) pc_next = pc_reg + 12'd4;
                            end else sts_next = ST_UNKNOWN;
                        end
                        default: begin
                            case (k8)
                                8'h07: v_next[x] = dt_reg;
                                8'h0A: begin
                                    if (key_reg == '0) begin
                                        wait_next = 1'b1;
                                        pc_next = pc_reg;
                                    end else v_next[x] = {3'd0, key_first};
                                end
                                8'h15: dt_next = ax;
                                8'h18: st_next = ax;
                                8'h1E: i_next = i_reg + {8'd0, ax};
                                8'h29: i_next = {10'd0, ax[3:0], 2'd0}
                                                + {12'd0, ax[3:0]};
                                8'h33: state_next = S_BCD;
                                8'h55: state_next = S_STORE;
                                8'h65: state_next = S_LOAD_RD;
                                default: sts_next = ST_UNKNOWN;
                            endcase
                        end
                    endcase
                end
            end
            S_CLS: begin
                if (fb_reg[cnt_reg] != '0) chg_next = 1'b1;
                fb_we = 1'b1;
                fb_wdata = '0;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = S_OUT;
            end
            S_DRW_RD: begin
                mem_raddr = maddr(i_off);
                state_next = S_DRW_ROW;
            end
            S_DRW_ROW: begin
                fb_idx = vy[4:0] + cnt_reg;
                fb_we = 1'b1;
                fb_wdata = fb_reg[fb_idx] ^ spr_mask;
                if ((fb_reg[fb_idx] & spr_mask) != '0) hit_next = 1'b1;
                if (spr_mask != '0) chg_next = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg + 5'd1 == {1'b0, fn}) begin
                    v_next[15] = {7'd0, hit_reg || ((fb_reg[fb_idx] & spr_mask) != '0)};
                    pc_next = pc_reg + 12'd2;
                    state_next = S_OUT;
                end else state_next = S_DRW_RD;
            end
            S_BCD: begin
                mem_we = 1'b1;
                mem_wdata = (cnt_reg == 5'd0) ? hund : (cnt_reg == 5'd1) ? tens : ones;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2) state_next = S_OUT;
            end
            S_STORE: begin
                mem_we = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[3:0] == fx) state_next = S_OUT;
            end
            S_LOAD_RD: begin
                mem_raddr = maddr(i_off);
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                v_next[cnt_reg[3:0]] = mem_rdata;
                cnt_next = cnt_reg + 5'd1;
                state_next = (cnt_reg[3:0] == fx) ? S_OUT : S_LOAD_RD;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            start_reg <= PcResetDefault;
            pc_reg <= PcResetDefault;
            for (int k = 0; k < 16; k++) v_reg[k] <= '0;
            for (int r = 0; r < 32; r++) fb_reg[r] <= '0;
            i_reg <= '0;
            dt_reg <= '0;
            st_reg <= '0;
            lvl_reg <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg <= cfg_we ? pwdata[11:0] : pc_next;
            for (int k = 0; k < 16; k++) v_reg[k] <= v_next[k];
            if (fb_we) fb_reg[fb_idx] <= fb_wdata;
            i_reg <= i_next;
            dt_reg <= dt_next;
            st_reg <= st_next;
            lvl_reg <= lvl_next;
            if (cfg_we) start_reg <= pwdata[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= s_key_mask;
            rnd_reg <= s_random_byte;
        end
        hi_reg <= hi_next;
        ir_reg <= ir_next;
        cnt_reg <= cnt_next;
        hit_reg <= hit_next;
        chg_reg <= chg_next;
        wait_reg <= wait_next;
        sts_reg <= sts_next;
        pix_reg <= pix_next;
    end
endmodule

>>> sim/chip8_cpu_core_tb.sv
`timescale 1ns / 1ps

module chip8_cpu_core_tb;
    import c8_pkg::*;

    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  ITEMS_PER_PHASE = 580;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] address;
        logic [7:0]  data;
        logic [4:0]  row;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } cmd_t;

    typedef struct packed {
        logic [11:0] pc;
        logic [63:0] row_pixels;
        logic        display_changed;
        logic        waiting_key;
        logic [1:0]  status;
    } outcome_t;

    class chip8_scoreboard;
        logic [7:0]  mem [MemDepthDefault];
        bit          written [MemDepthDefault];
        logic [7:0]  regs [16];
        logic [15:0] index;
        logic [7:0]  delay_t, sound_t;
        logic [11:0] pc, start;
        logic [11:0] stack [StackDepthDefault];
        int          level;
        logic [63:0] frame [32];
        outcome_t    pending_q [$];
        int          errors;

        function new();
            errors = 0;
            for (int k = 0; k < MemDepthDefault; k++) begin
                mem[k] = 8'h00;
                written[k] = 0;
            end
            for (int k = 0; k < 16; k++) regs[k] = 8'h00;
            for (int k = 0; k < 32; k++) frame[k] = 64'h0;
            for (int k = 0; k < StackDepthDefault; k++) stack[k] = 12'h0;
            index = 16'h0;
            delay_t = 8'h0;
            sound_t = 8'h0;
            level = 0;
            start = PcResetDefault;
            pc = start;
        endfunction

        function void set_start(logic [11:0] v);
            start = v;
            pc = v;
        endfunction

        function int mix(logic [15:0] a);
            return int'(a[11:0]) % MemDepthDefault;
        endfunction

        function void step_pc(logic [11:0] d);
            pc = pc + d;
        endfunction

        function void execute(logic [15:0] keys, logic [7:0] rnd, ref outcome_t r);
            logic [15:0] w;
            logic [3:0]  x, y, n;
            logic [7:0]  kk, vx, vy, res, b;
            logic [11:0] nnn;
            logic [8:0]  sum;
            logic [63:0] mask;
            logic        flag, hit, sets_flag;
            logic [4:0]  line;
            int          k;
            w = {mem[mix({4'h0, pc})], mem[mix({4'h0, pc} + 16'd1)]};
            x = w[11:8];
            y = w[7:4];
            n = w[3:0];
            kk = w[7:0];
            nnn = w[11:0];
            vx = regs[x];
            vy = regs[y];
            case (w[15:12])
                4'h0: begin
                    if (w == 16'h00E0) begin
                        for (k = 0; k < 32; k++) begin
                            if (frame[k] != 64'h0) r.display_changed = 1'b1;
                            frame[k] = 64'h0;
                        end
                        step_pc(12'd2);
                    end else if (w == 16'h00EE) begin
                        if (level == 0) begin
                            r.status = ST_UNDERFLOW;
                            step_pc(12'd2);
                        end else begin
                            level--;
                            pc = stack[level];
                        end
                    end else begin
                        step_pc(12'd2);
                    end
                end
                4'h1: pc = nnn;
                4'h2: begin
                    if (level >= StackDepthDefault) begin
                        r.status = ST_OVERFLOW;
                        step_pc(12'd2);
                    end else begin
                        stack[level] = pc + 12'd2;
                        level++;
                        pc = nnn;
                    end
                end
                4'h3: step_pc(vx == kk ? 12'd4 : 12'd2);
                4'h4: step_pc(vx != kk ? 12'd4 : 12'd2);
                4'h5: begin
                    if (n != 4'h0) begin
                        r.status = ST_UNKNOWN;
                        step_pc(12'd2);
                    end else step_pc(vx == vy ? 12'd4 : 12'd2);
                end
                4'h6: begin regs[x] = kk; step_pc(12'd2); end
                4'h7: begin regs[x] = vx + kk; step_pc(12'd2); end
                4'h8: begin
                    sets_flag = 1'b1;
                    flag = 1'b0;
                    res = vx;
                    case (n)
                        4'h0: begin res = vy; sets_flag = 1'b0; end
                        4'h1: begin res = vx | vy; sets_flag = 1'b0; end
                        4'h2: begin res = vx & vy; sets_flag = 1'b0; end
                        4'h3: begin res = vx ^ vy; sets_flag = 1'b0; end
                        4'h4: begin sum = vx + vy; res = sum[7:0]; flag = sum[8]; end
                        4'h5: begin res = vx - vy; flag = vx >= vy; end
                        4'h6: begin res = vx >> 1; flag = vx[0]; end
                        4'h7: begin res = vy - vx; flag = vy >= vx; end
                        4'hE: begin res = {vx[6:0], 1'b0}; flag = vx[7]; end
                        default: begin
                            r.status = ST_UNKNOWN;
                            step_pc(12'd2);
                            return;
                        end
                    endcase
                    regs[x] = res;
                    if (sets_flag) regs[15] = {7'h0, flag};
                    step_pc(12'd2);
                end
                4'h9: begin
                    if (n != 4'h0) begin
                        r.status = ST_UNKNOWN;
                        step_pc(12'd2);
                    end else step_pc(vx != vy ? 12'd4 : 12'd2);
                end
                4'hA: begin index = {4'h0, nnn}; step_pc(12'd2); end
                4'hB: pc = nnn + {4'h0, regs[0]};
                4'hC: begin regs[x] = rnd & kk; step_pc(12'd2); end
                4'hD: begin
                    hit = 1'b0;
                    for (k = 0; k < n; k++) begin
                        b = mem[mix(index + 16'(k))];
                        mask = 64'h0;
                        for (int c = 0; c < 8; c++)
                            if (b[7-c]) mask[(int'(vx) + c) % 64] = 1'b1;
                        line = vy[4:0] + 5'(k);
                        if ((frame[line] & mask) != 64'h0) hit = 1'b1;
                        if (mask != 64'h0) r.display_changed = 1'b1;
                        frame[line] ^= mask;
                    end
                    regs[15] = {7'h0, hit};
                    step_pc(12'd2);
                end
                4'hE: begin
                    if (kk == 8'h9E) step_pc(keys[vx[3:0]] ? 12'd4 : 12'd2);
                    else if (kk == 8'hA1) step_pc(!keys[vx[3:0]] ? 12'd4 : 12'd2);
                    else begin
                        r.status = ST_UNKNOWN;
                        step_pc(12'd2);
                    end
                end
                default: begin
                    case (kk)
                        8'h07: regs[x] = delay_t;
                        8'h0A: begin
                            if (keys == 16'h0) begin
                                r.waiting_key = 1'b1;
                                return;
                            end
                            for (k = 15; k >= 0; k--)
                                if (keys[k]) regs[x] = 8'(k);
                        end
                        8'h15: delay_t = vx;
                        8'h18: sound_t = vx;
                        8'h1E: index = index + {8'h0, vx};
                        8'h29: index = 16'(vx[3:0]) * 16'd5;
                        8'h33: begin
                            mem[mix(index)] = vx / 100;
                            mem[mix(index + 16'd1)] = (vx / 10) % 10;
                            mem[mix(index + 16'd2)] = vx % 10;
                            for (k = 0; k < 3; k++) written[mix(index + 16'(k))] = 1;
                        end
                        8'h55: begin
                            for (k = 0; k <= x; k++) begin
                                mem[mix(index + 16'(k))] = regs[k];
                                written[mix(index + 16'(k))] = 1;
                            end
                        end
                        8'h65: begin
                            for (k = 0; k <= x; k++) regs[k] = mem[mix(index + 16'(k))];
                        end
                        default: r.status = ST_UNKNOWN;
                    endcase
                    step_pc(12'd2);
                end
            endcase
        endfunction

        function void note_input(cmd_t c);
            outcome_t r;
            r = '0;
            case (c.opcode)
                OP_WRITE: begin
                    mem[mix({4'h0, c.address})] = c.data;
                    written[mix({4'h0, c.address})] = 1;
                end
                OP_EXEC: execute(c.key_mask, c.random_byte, r);
                OP_READ: r.row_pixels = frame[c.row];
                default: ;
            endcase
            r.pc = pc;
            pending_q.push_back(r);
        endfunction

        function void check(outcome_t act);
            outcome_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction pc=%h", act.pc);
                return;
            end
            e = pending_q.pop_front();
            if (e != act) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp pc=%h pix=%h chg=%b wait=%b st=%0d | got pc=%h pix=%h chg=%b wait=%b st=%0d",
                             e.pc, e.row_pixels, e.display_changed, e.waiting_key, e.status,
                             act.pc, act.row_pixels, act.display_changed, act.waiting_key,
                             act.status);
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [1:0]  s_opcode;
    logic [11:0] s_address;
    logic [7:0]  s_data;
    logic [4:0]  s_row;
    logic [15:0] s_key_mask;
    logic [7:0]  s_random_byte;
    logic        m_valid, m_ready;
    logic [11:0] m_pc;
    logic [63:0] m_row_pixels;
    logic        m_display_changed, m_waiting_key;
    logic [1:0]  m_status;

    chip8_cpu_core dut (.*);

    chip8_scoreboard sb;
    int tx_idle, rx_idle, items_sent, cycles;
    int hold_req, hold_ack, hold_left;

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random back-pressure plus an occasional long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check('{m_pc, m_row_pixels, m_display_changed, m_waiting_key, m_status});
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    task automatic send_cmd(cmd_t c);
        if ($urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_opcode, s_address, s_data, s_row, s_key_mask, s_random_byte} <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(c);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0;
            1: return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cmd_t rand_cmd(logic [1:0] op);
        cmd_t c;
        c.opcode = op;
        c.address = 12'($urandom);
        c.data = 8'($urandom);
        c.row = 5'($urandom);
        c.key_mask = pick_keys();
        c.random_byte = 8'($urandom);
        return c;
    endfunction

    task automatic write_byte(logic [11:0] a, logic [7:0] d);
        cmd_t c;
        c = rand_cmd(OP_WRITE);
        c.address = a;
        c.data = d;
        send_cmd(c);
    endtask

    // place the instruction at the predicted PC, back any sprite or load data, run it
    task automatic run_instr(logic [15:0] w, logic [15:0] keys);
        cmd_t c;
        logic [11:0] a;
        int cnt;
        a = sb.pc;
        write_byte(a, w[15:8]);
        write_byte(a + 12'd1, w[7:0]);
        cnt = 0;
        if (w[15:12] == 4'hD) cnt = w[3:0];
        else if (w[15:12] == 4'hF && w[7:0] == 8'h65) cnt = int'(w[11:8]) + 1;
        for (int k = 0; k < cnt; k++) begin
            a = sb.index[11:0] + 12'(k);
            if (!sb.written[a]) write_byte(a, 8'($urandom));
        end
        c = rand_cmd(OP_EXEC);
        c.key_mask = keys;
        send_cmd(c);
    endtask

    function automatic logic [15:0] make_instr();
        logic [15:0] w;
        logic [3:0]  x;
        logic [7:0]  fx [10];
        fx = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h07};
        w = 16'($urandom);
        x = w[11:8];
        case (w[15:12])
            4'h0: case ($urandom_range(0, 3))
                0: w = 16'h00E0;
                1, 2: w = 16'h00EE;
                default: ;
            endcase
            4'h3, 4'h4: if ($urandom_range(0, 1)) w[7:0] = sb.regs[x];
            4'h5, 4'h9: begin
                if ($urandom_range(0, 7) != 0) w[3:0] = 4'h0;
                if ($urandom_range(0, 2) == 0) w[7:4] = x;
            end
            4'h8: if ($urandom_range(0, 7) != 0) begin
                w[3:0] = 4'($urandom_range(0, 8));
                if (w[3:0] == 4'h8) w[3:0] = 4'hE;
            end
            4'hE: case ($urandom_range(0, 4))
                0, 1: w[7:0] = 8'h9E;
                2, 3: w[7:0] = 8'hA1;
                default: ;
            endcase
            4'hF: if ($urandom_range(0, 9) != 0) w[7:0] = fx[$urandom_range(0, 9)];
            default: ;
        endcase
        return w;
    endfunction

    task automatic apb_write(logic [1:0] a, logic [31:0] d);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check(logic [1:0] a, logic [31:0] want);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= a;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[11:0] != want[11:0]) begin
            sb.errors++;
            if (sb.errors <= 10) $display("register read: exp %h got %h", want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_program_start(logic [11:0] v);
        apb_write(2'(4 * REG_PROGRAM_START), {20'h0, v});
        sb.set_start(v);
        apb_check(2'(4 * REG_PROGRAM_START), {20'h0, v});
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic random_phase(int quota, bit do_hold, bit do_pause);
        int target;
        target = items_sent + quota;
        while (items_sent < target) begin
            if (do_hold && items_sent > target - quota / 2) begin
                hold_req <= hold_req + 1;
                do_hold = 0;
            end
            if (do_pause && items_sent > target - quota / 3) begin
                s_valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge aclk);
                do_pause = 0;
            end
            case ($urandom_range(0, 19))
                0: send_cmd(rand_cmd(OP_READ));
                1: send_cmd(rand_cmd(OP_WRITE));
                2: send_cmd(rand_cmd(2'd3));
                default: run_instr(make_instr(), pick_keys());
            endcase
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        items_sent = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        tx_idle = 23;
        rx_idle = 71;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        {s_opcode, s_address, s_data, s_row, s_key_mask, s_random_byte} <= '0;
        m_ready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_program_start(PcResetDefault);
        // carry, underflow, wrapped draw, key wait, unknown, clear
        run_instr(16'h60FF, 16'h0);
        run_instr(16'h8014, 16'h0);
        run_instr(16'h00EE, 16'h0);
        run_instr(16'hAFFE, 16'h0);
        run_instr(16'hD00F, 16'h0);
        run_instr(16'hF00A, 16'h0);
        run_instr(16'hF00A, 16'hFFFF);
        run_instr(16'h800F, 16'h0);
        run_instr(16'h00E0, 16'h0);
        send_cmd(rand_cmd(2'd3));
        drain();

        set_program_start(12'h000);
        random_phase(ITEMS_PER_PHASE, 1'b1, 1'b0);
        drain();

        tx_idle = 71;
        rx_idle = 23;
        set_program_start(12'hFFF);
        random_phase(ITEMS_PER_PHASE, 1'b0, 1'b1);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        set_program_start(12'($urandom_range(512, 4000)));
        random_phase(ITEMS_PER_PHASE, 1'b0, 1'b0);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> chip8_cpu_core.f
rtl/core/c8_pkg.sv
rtl/core/c8_ram.sv
rtl/core/chip8_cpu_core.sv
sim/chip8_cpu_core_tb.sv
